>>> rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared widths, codes and beat types of the line pixel stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

    localparam int COORD_WIDTH = 10;
    localparam int PIX_WIDTH   = 11;
    localparam int COLOR_WIDTH = 16;
    localparam int ORIENT_WIDTH = 2;

    // error never goes above twice the major distance
    localparam int ERR_WIDTH = COORD_WIDTH + 2;
    // pixel count holds major distance + 1
    localparam int CNT_WIDTH = COORD_WIDTH + 1;
    // room for a coordinate plus the panel offset before trimming
    localparam int OFS_WIDTH = ((COORD_WIDTH > PIX_WIDTH) ? COORD_WIDTH : PIX_WIDTH) + 1;

    localparam logic [OFS_WIDTH-1:0] PANEL_OFFSET = OFS_WIDTH'(80);

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam logic [ORIENT_WIDTH-1:0] ORIENT_ROW_SHIFT = 2'd1;
    localparam logic [ORIENT_WIDTH-1:0] ORIENT_COL_SHIFT = 2'd3;

    typedef struct packed {
        logic                   mode;
        logic [COORD_WIDTH-1:0] start_col;
        logic [COORD_WIDTH-1:0] start_row;
        logic [COORD_WIDTH-1:0] end_col;
        logic [COORD_WIDTH-1:0] end_row;
        logic [COLOR_WIDTH-1:0] color;
    } item_t;

    typedef struct packed {
        logic [PIX_WIDTH-1:0]   pixel_col;
        logic [PIX_WIDTH-1:0]   pixel_row;
        logic [COLOR_WIDTH-1:0] pixel_color;
        logic                   last;
    } pixel_t;

    typedef struct packed {
        logic emit;
        logic busy;
    } lps_status_t;

endpackage

`default_nettype wire

>>> rtl/lps_stepper.sv
// ----------------------------------------------------------------------------
// lps_stepper
// Line state and error update; one step per accepted tick beat while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_stepper
    import lps_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    fire,
    input  wire item_t                   item,
    input  wire logic [ORIENT_WIDTH-1:0] orientation,
    output lps_status_t                  status,
    output pixel_t                       pixel
);

    logic [COORD_WIDTH-1:0] cur_col_reg, cur_col_next;
    logic [COORD_WIDTH-1:0] cur_row_reg, cur_row_next;
    logic [ERR_WIDTH-1:0]   col_err_reg, col_err_next;
    logic [ERR_WIDTH-1:0]   row_err_reg, row_err_next;
    logic [COORD_WIDTH-1:0] abs_dcol_reg, abs_dcol_next;
    logic [COORD_WIDTH-1:0] abs_drow_reg, abs_drow_next;
    logic [COORD_WIDTH-1:0] major_reg, major_next;
    logic                   col_neg_reg, col_neg_next;
    logic                   row_neg_reg, row_neg_next;
    logic [CNT_WIDTH-1:0]   left_reg, left_next;
    logic [COLOR_WIDTH-1:0] color_reg, color_next;

    logic                   busy;
    logic                   emit;
    logic [ERR_WIDTH-1:0]   col_sum, row_sum;
    logic                   col_hit, row_hit;
    logic [OFS_WIDTH-1:0]   col_ofs, row_ofs;

    assign busy = (left_reg != '0);
    assign emit = fire && (item.mode == MODE_TICK) && busy;

    assign status.emit = emit;
    assign status.busy = busy;

    assign col_sum = col_err_reg + ERR_WIDTH'(abs_dcol_reg);
    assign row_sum = row_err_reg + ERR_WIDTH'(abs_drow_reg);
    assign col_hit = col_sum > ERR_WIDTH'(major_reg);
    assign row_hit = row_sum > ERR_WIDTH'(major_reg);

    // orientation offset, trimmed to the panel address width
    always_comb
    begin
        col_ofs = '0;
        row_ofs = '0;
        if (orientation == ORIENT_ROW_SHIFT)
        begin
            row_ofs = PANEL_OFFSET;
        end
        else if (orientation == ORIENT_COL_SHIFT)
        begin
            col_ofs = PANEL_OFFSET;
        end
    end

    always_comb
    begin
        pixel.pixel_col   = PIX_WIDTH'(OFS_WIDTH'(cur_col_reg) + col_ofs);
        pixel.pixel_row   = PIX_WIDTH'(OFS_WIDTH'(cur_row_reg) + row_ofs);
        pixel.pixel_color = color_reg;
        pixel.last        = (left_reg == CNT_WIDTH'(1));
    end

    always_comb
    begin
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        col_err_next  = col_err_reg;
        row_err_next  = row_err_reg;
        abs_dcol_next = abs_dcol_reg;
        abs_drow_next = abs_drow_reg;
        major_next    = major_reg;
        col_neg_next  = col_neg_reg;
        row_neg_next  = row_neg_reg;
        left_next     = left_reg;
        color_next    = color_reg;

        if (fire && (item.mode == MODE_START))
        begin
            col_neg_next  = item.end_col < item.start_col;
            row_neg_next  = item.end_row < item.start_row;
            abs_dcol_next = col_neg_next ? (item.start_col - item.end_col)
                                         : (item.end_col - item.start_col);
            abs_drow_next = row_neg_next ? (item.start_row - item.end_row)
                                         : (item.end_row - item.start_row);
            major_next    = (abs_dcol_next > abs_drow_next) ? abs_dcol_next
                                                            : abs_drow_next;
            cur_col_next  = item.start_col;
            cur_row_next  = item.start_row;
            col_err_next  = '0;
            row_err_next  = '0;
            left_next     = CNT_WIDTH'(major_next) + CNT_WIDTH'(1);
            color_next    = item.color;
        end
        else if (emit)
        begin
            // an axis with zero distance never hits, so its sign is irrelevant
            if (col_hit)
            begin
                col_err_next = col_sum - ERR_WIDTH'(major_reg);
                cur_col_next = col_neg_reg ? (cur_col_reg - COORD_WIDTH'(1))
                                           : (cur_col_reg + COORD_WIDTH'(1));
            end
            else
            begin
                col_err_next = col_sum;
            end
            if (row_hit)
            begin
                row_err_next = row_sum - ERR_WIDTH'(major_reg);
                cur_row_next = row_neg_reg ? (cur_row_reg - COORD_WIDTH'(1))
                                           : (cur_row_reg + COORD_WIDTH'(1));
            end
            else
            begin
                row_err_next = row_sum;
            end
            left_next = left_reg - CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            col_err_reg  <= '0;
            row_err_reg  <= '0;
            abs_dcol_reg <= '0;
            abs_drow_reg <= '0;
            major_reg    <= '0;
            col_neg_reg  <= 1'b0;
            row_neg_reg  <= 1'b0;
            left_reg     <= '0;
            color_reg    <= '0;
        end
        else
        begin
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            col_err_reg  <= col_err_next;
            row_err_reg  <= row_err_next;
            abs_dcol_reg <= abs_dcol_next;
            abs_drow_reg <= abs_drow_next;
            major_reg    <= major_next;
            col_neg_reg  <= col_neg_next;
            row_neg_reg  <= row_neg_next;
            left_reg     <= left_next;
            color_reg    <= color_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/line_pixel_stepper.sv
// ----------------------------------------------------------------------------
// line_pixel_stepper
// Walks the pixels of a straight line, one pixel per tick beat while it runs.
// ----------------------------------------------------------------------------
// A start beat loads two endpoints and a colour and returns nothing; each
// following tick beat returns the next pixel of the line (panel column and
// row with the orientation offset applied, colour, and last on the final
// pixel), and ticks while no line is running return nothing. One beat is
// taken every clock cycle while the pixel output register is empty or being
// drained; a pixel is registered in the cycle after its tick beat, and the
// single output register takes no new beat while a pixel waits. The
// orientation register should only be written while no line is in flight.
`default_nettype none

module line_pixel_stepper
    import lps_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [ORIENT_WIDTH-1:0] cfg_data,

    input  wire logic                    item_valid,
    output logic                         item_ready,
    input  wire item_t                   item,

    output logic                         pixel_valid,
    input  wire logic                    pixel_ready,
    output pixel_t                       pixel
);

    logic [ORIENT_WIDTH-1:0] orientation_reg;
    logic                    pixel_valid_reg;
    pixel_t                  pixel_reg;
    logic                    fire;
    lps_status_t             status;
    pixel_t                  step_pixel;

    assign cfg_ready   = 1'b1;
    assign item_ready  = !pixel_valid_reg || pixel_ready;
    assign fire        = item_valid && item_ready;
    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;

    lps_stepper u_stepper (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item),
        .orientation (orientation_reg),
        .status      (status),
        .pixel       (step_pixel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            orientation_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid_reg <= 1'b0;
        end
        else if (status.emit)
        begin
            pixel_valid_reg <= 1'b1;
        end
        else if (pixel_ready)
        begin
            pixel_valid_reg <= 1'b0;
        end
    end

    // pixel payload needs no reset
    always_ff @(posedge clk)
    begin
        if (status.emit)
        begin
            pixel_reg <= step_pixel;
        end
    end

    // an empty output register never holds back an input beat
    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_valid |-> item_ready)
        else $error("input stalled with empty pixel register");

    // a start beat into a draining output leaves no pixel behind
    a_start_no_pixel : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.mode == MODE_START) && (!pixel_valid || pixel_ready))
        |=> !pixel_valid)
        else $error("pixel produced by a start beat");

    // the line ends with the pixel flagged last
    a_last_ends_line : assert property (@(posedge clk) disable iff (!rst_n)
        (status.emit && step_pixel.last) |=> !status.busy)
        else $error("line still running after last pixel");

    // a tick with no line running gives no pixel
    a_idle_tick : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !status.busy) |-> !status.emit)
        else $error("pixel emitted while idle");

endmodule

`default_nettype wire
